// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is active
`define BVR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication check, disabled while reset is active
`define BVR_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== rtl/bvr_pkg.sv =====
// shared types, constants and key code lookup for the button repeat tracker
`default_nettype none

package bvr_pkg;

    localparam int NUM_BUTTONS = 18;
    localparam int ID_W        = 5;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CODE_W      = 16;
    localparam int VAL_W       = 8;
    localparam int ETYPE_W     = 16;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 96;
    localparam int OUT_PAD_W   = OUT_DATA_W - 5 * NUM_BUTTONS;

    localparam logic [ETYPE_W-1:0] KEY_EVENT     = 16'd1;
    localparam logic [VAL_W-1:0]   KEY_VALUE_MAX = 8'd1;
    localparam logic               REQ_POLL      = 1'b0;

    // register indexes, selected by paddr[2]
    localparam logic REG_DELAY    = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    localparam logic [CFG_W-1:0] DELAY_RESET    = 16'd300;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd100;

    // raw key code of each button id
    localparam logic [CODE_W-1:0] CODE_TABLE [NUM_BUTTONS] = '{
        16'd103, 16'd108, 16'd105, 16'd106, 16'd57, 16'd29, 16'd42, 16'd56, 16'd28,
        16'd97, 16'h01, 16'd18, 16'd15, 16'd20, 16'd14, 16'd115, 16'd114, 16'd116
    };

    // per-button timing state held in one cell
    typedef struct packed {
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] next_repeat;
    } cell_t;

    // what the head unit does with the button now at the head
    typedef struct packed {
        logic is_poll;
        logic at_key;
        logic key_press;
    } op_t;

    // mask changes for the button at the head
    typedef struct packed {
        logic set_repeat;
        logic set_pressed;
        logic set_held;
        logic clr_held;
        logic clr_repeat;
        logic set_long;
        logic set_short;
    } flags_t;

    // maps a key code to {hit, id}
    function automatic logic [ID_W:0] lookup_button(input logic [CODE_W-1:0] code);
        logic [ID_W:0] res;
        res = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (CODE_TABLE[i] == code) begin
                res = {1'b1, ID_W'(i)};
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bvr_cell.sv =====
// one link of the rotating chain that holds a button's press and repeat times
`default_nettype none

module bvr_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           shift,
    input  wire bvr_pkg::cell_t d_in,
    output bvr_pkg::cell_t      d_out
);

    bvr_pkg::cell_t data_reg;
    bvr_pkg::cell_t data_next;

    // take the neighbor's contents while the chain rotates
    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = d_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

`default_nettype wire

// ===== rtl/bvr_update.sv =====
// head unit: updates the button at the head of the chain and reports mask changes
`default_nettype none

module bvr_update (
    input  wire bvr_pkg::cell_t                  head,
    input  wire bvr_pkg::op_t                    op,
    input  wire logic                            held_bit,
    input  wire logic [bvr_pkg::TIME_W-1:0]      poll_time,
    input  wire logic [bvr_pkg::CFG_W-1:0]       delay,
    input  wire logic [bvr_pkg::CFG_W-1:0]       interval,
    output bvr_pkg::cell_t                       tail,
    output bvr_pkg::flags_t                      flags
);

    logic [bvr_pkg::TIME_W-1:0] dur;
    logic [bvr_pkg::CFG_W:0]    limit;

    assign dur   = poll_time - head.press_time;
    assign limit = {1'b0, delay} + {1'b0, interval};

    always_comb
    begin
        tail  = head;
        flags = '0;
        if (op.is_poll)
        begin
            // auto repeat fires once the next repeat time has come
            if (held_bit && (poll_time >= head.next_repeat))
            begin
                flags.set_repeat = 1'b1;
                tail.next_repeat = head.next_repeat
                                 + {{(bvr_pkg::TIME_W-bvr_pkg::CFG_W){1'b0}}, interval};
            end
        end
        else if (op.at_key)
        begin
            if (!op.key_press)
            begin
                // release: classify by held duration, only if it was held
                if (held_bit)
                begin
                    if (dur > {{(bvr_pkg::TIME_W-bvr_pkg::CFG_W-1){1'b0}}, limit})
                    begin
                        flags.set_long = 1'b1;
                    end
                    else
                    begin
                        flags.set_short = 1'b1;
                    end
                end
                flags.clr_held   = 1'b1;
                flags.clr_repeat = 1'b1;
                tail.press_time  = '0;
            end
            else if (!held_bit)
            begin
                // fresh press: record start and first repeat time
                flags.set_pressed = 1'b1;
                flags.set_held    = 1'b1;
                tail.press_time   = poll_time;
                tail.next_repeat  = poll_time
                                  + {{(bvr_pkg::TIME_W-bvr_pkg::CFG_W){1'b0}}, delay};
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/button_event_repeat_tracker.sv =====
// Button event repeat tracker: each transaction rotates the chain of button cells
// once, one button per cycle through the head unit, then loads the result.
// The result is loaded into the output register from the done state, which waits
// while a stalled result still fills it; no new transaction is taken until then.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst_n low, asynchronous) clears masks, times and poll time, config to defaults.
`default_nettype none

module button_event_repeat_tracker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata from bit 0: now_ms[31:0], event_type[47:32], key_code[63:48],
    // key_value[71:64]
    input  wire logic [bvr_pkg::IN_DATA_W-1:0]    s_tdata,
    // s_tuser: req_type[0]
    input  wire logic                             s_tuser,
    // output stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata from bit 0: held_buttons[17:0], newly_pressed[35:18],
    // released_long[53:36], released_short[71:54], repeated[89:72], zeros[95:90]
    output logic [bvr_pkg::OUT_DATA_W-1:0]        m_tdata,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [2:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int N = bvr_pkg::NUM_BUTTONS;

    logic [1:0]                    state_reg, state_next;
    logic [bvr_pkg::ID_W-1:0]      pos_reg, pos_next;
    logic [bvr_pkg::CFG_W-1:0]     delay_reg, interval_reg;
    logic [bvr_pkg::TIME_W-1:0]    poll_time_reg, poll_time_next;
    logic                          poll_reg, key_ok_reg, press_reg;
    logic [bvr_pkg::ID_W-1:0]      id_reg;
    logic [N-1:0]                  held_reg, pressed_reg, long_reg, short_reg, repeat_reg;
    logic [N-1:0]                  held_next, pressed_next, long_next, short_next;
    logic [N-1:0]                  repeat_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [bvr_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                          accept;
    logic                          step;
    logic                          cfg_wr;
    logic [bvr_pkg::ID_W:0]        lookup;
    logic                          key_ok;

    bvr_pkg::cell_t                chain [N];
    bvr_pkg::cell_t                tail;
    bvr_pkg::op_t                  op;
    bvr_pkg::flags_t               flags;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign step     = (state_reg == ST_RUN);
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // decode the incoming key event
    assign lookup = bvr_pkg::lookup_button(s_tdata[63:48]);
    assign key_ok = (s_tdata[47:32] == bvr_pkg::KEY_EVENT)
                 && (s_tdata[71:64] <= bvr_pkg::KEY_VALUE_MAX)
                 && lookup[bvr_pkg::ID_W];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= bvr_pkg::DELAY_RESET;
            interval_reg <= bvr_pkg::INTERVAL_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                bvr_pkg::REG_DELAY:    delay_reg    <= pwdata[bvr_pkg::CFG_W-1:0];
                bvr_pkg::REG_INTERVAL: interval_reg <= pwdata[bvr_pkg::CFG_W-1:0];
                default:               delay_reg    <= delay_reg;
            endcase
        end
    end

    assign prdata = {16'd0, (paddr[2] == bvr_pkg::REG_INTERVAL) ? interval_reg : delay_reg};

    // rotating chain of button cells, head at index 0, tail fed by the head unit
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        bvr_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (step),
            .d_in  ((g == N - 1) ? tail : chain[(g + 1) % N]),
            .d_out (chain[g])
        );
    end

    assign op.is_poll   = (poll_reg == 1'b1);
    assign op.at_key    = key_ok_reg && (pos_reg == id_reg);
    assign op.key_press = press_reg;

    bvr_update u_update (
        .head      (chain[0]),
        .op        (op),
        .held_bit  (held_reg[pos_reg]),
        .poll_time (poll_time_reg),
        .delay     (delay_reg),
        .interval  (interval_reg),
        .tail      (tail),
        .flags     (flags)
    );

    // sequencer, masks and output register
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        poll_time_next = poll_time_reg;
        held_next      = held_reg;
        pressed_next   = pressed_reg;
        long_next      = long_reg;
        short_next     = short_reg;
        repeat_next    = repeat_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    pos_next   = '0;
                    if (s_tuser == bvr_pkg::REQ_POLL)
                    begin
                        poll_time_next = s_tdata[31:0];
                        pressed_next   = '0;
                        long_next      = '0;
                        short_next     = '0;
                        repeat_next    = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (flags.set_repeat)  repeat_next[pos_reg]  = 1'b1;
                if (flags.clr_repeat)  repeat_next[pos_reg]  = 1'b0;
                if (flags.set_pressed) pressed_next[pos_reg] = 1'b1;
                if (flags.set_held)    held_next[pos_reg]    = 1'b1;
                if (flags.clr_held)    held_next[pos_reg]    = 1'b0;
                if (flags.set_long)    long_next[pos_reg]    = 1'b1;
                if (flags.set_short)   short_next[pos_reg]   = 1'b1;
                if (pos_reg == bvr_pkg::ID_W'(N - 1))
                begin
                    pos_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{bvr_pkg::OUT_PAD_W{1'b0}}, repeat_reg, short_reg,
                                     long_reg, pressed_reg, held_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            poll_time_reg <= '0;
            held_reg      <= '0;
            pressed_reg   <= '0;
            long_reg      <= '0;
            short_reg     <= '0;
            repeat_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            poll_time_reg <= poll_time_next;
            held_reg      <= held_next;
            pressed_reg   <= pressed_next;
            long_reg      <= long_next;
            short_reg     <= short_next;
            repeat_reg    <= repeat_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // latched item fields and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            poll_reg   <= (s_tuser == bvr_pkg::REQ_POLL);
            key_ok_reg <= key_ok;
            press_reg  <= s_tdata[64];
            id_reg     <= lookup[bvr_pkg::ID_W-1:0];
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/bvr_checker.sv =====
// port-level checks for the button repeat tracker, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module bvr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);

    // a stalled result keeps its payload
    `BVR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "result changed while stalled")

    // the block goes busy right after taking a transaction
    `BVR_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready,
        "ready stayed high after accept")

    // no result appears the cycle after an idle block with an empty output
    `BVR_ASSERT(a_no_spurious_out, s_tready && !m_tvalid |=> !m_tvalid,
        "result without a transaction")

    // a repeating button is always a held button
    `BVR_ASSERT_IMP(a_repeat_held, m_tvalid, (m_tdata[89:72] & ~m_tdata[17:0]) == 18'd0,
        "repeat bit on a button not held")

endmodule

bind button_event_repeat_tracker bvr_checker u_bvr_checker (.*);

`default_nettype wire

// ===== verif/button_event_repeat_tracker_test.sv =====
// self-checking testbench for the button event repeat tracker: directed, extreme and random traffic
`default_nettype none

module button_event_repeat_tracker_test;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 350;

    localparam logic           REQ_KEY     = 1'b1;
    localparam logic [7:0]     VAL_RELEASE = 8'd0;
    localparam logic [7:0]     VAL_PRESS   = 8'd1;

    // raw key code of each button id, in id order
    localparam logic [15:0] BUTTON_CODES [18] = '{
        16'd103, 16'd108, 16'd105, 16'd106, 16'd57, 16'd29, 16'd42, 16'd56, 16'd28,
        16'd97, 16'h0001, 16'd18, 16'd15, 16'd20, 16'd14, 16'd115, 16'd114, 16'd116
    };

    typedef struct packed {
        logic        req_type;
        logic [31:0] now_ms;
        logic [15:0] event_type;
        logic [15:0] key_code;
        logic [7:0]  key_value;
    } key_item_t;

    typedef struct packed {
        logic [17:0] held_buttons;
        logic [17:0] newly_pressed;
        logic [17:0] released_long;
        logic [17:0] released_short;
        logic [17:0] repeated;
    } mask_set_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [bvr_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [bvr_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [2:0]                     paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    // tracker copy kept by the testbench
    logic [17:0] trk_held;
    logic [17:0] trk_pressed;
    logic [17:0] trk_long;
    logic [17:0] trk_short;
    logic [17:0] trk_repeat;
    logic [31:0] trk_press_time [18];
    logic [31:0] trk_next_repeat [18];
    logic [31:0] trk_poll_time;
    logic [15:0] trk_delay;
    logic [15:0] trk_interval;

    mask_set_t   expected_masks [$];
    mask_set_t   oldest_mask;
    int          failures;
    int          cycles;
    int          send_idle_pct;
    int          stall_pct;
    logic [31:0] traffic_ms;

    button_event_repeat_tracker uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always #2 clk = ~clk;

    // receiver stalls
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("button_event_repeat_tracker verification failed");
        $finish;
    end

    // button id of a raw key code, -1 when unmapped
    function automatic int button_of(input logic [15:0] code);
        int id;
        id = -1;
        for (int i = 0; i < 18; i++)
        begin
            if (id < 0 && BUTTON_CODES[i] == code)
            begin
                id = i;
            end
        end
        return id;
    endfunction

    function automatic void compare_field(input string name, input logic [17:0] want,
                                          input logic [17:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %05h, actual %05h", name, want, got);
            failures++;
        end
    endfunction

    function automatic key_item_t poll_item(input logic [31:0] t);
        key_item_t it;
        it.req_type   = bvr_pkg::REQ_POLL;
        it.now_ms     = t;
        it.event_type = 16'($urandom);
        it.key_code   = 16'($urandom);
        it.key_value  = 8'($urandom);
        return it;
    endfunction

    function automatic key_item_t key_item(input logic [15:0] etype, input logic [15:0] code,
                                           input logic [7:0] value);
        key_item_t it;
        it.req_type   = REQ_KEY;
        it.now_ms     = $urandom;
        it.event_type = etype;
        it.key_code   = code;
        it.key_value  = value;
        return it;
    endfunction

    // clear the tracker copy to its reset state
    task automatic reset_masks();
        trk_held      = '0;
        trk_pressed   = '0;
        trk_long      = '0;
        trk_short     = '0;
        trk_repeat    = '0;
        trk_poll_time = '0;
        trk_delay     = bvr_pkg::DELAY_RESET;
        trk_interval  = bvr_pkg::INTERVAL_RESET;
        for (int i = 0; i < 18; i++)
        begin
            trk_press_time[i]  = '0;
            trk_next_repeat[i] = '0;
        end
    endtask

    // advance the tracker copy by one item and give the masks that follow
    task automatic predict_masks(input key_item_t it, output mask_set_t res);
        int          id;
        logic [17:0] bit_mask;
        logic [31:0] held_for;
        logic [31:0] long_limit;
        if (it.req_type == bvr_pkg::REQ_POLL)
        begin
            trk_poll_time = it.now_ms;
            trk_pressed   = '0;
            trk_long      = '0;
            trk_short     = '0;
            trk_repeat    = '0;
            for (int i = 0; i < 18; i++)
            begin
                if (trk_held[i] && it.now_ms >= trk_next_repeat[i])
                begin
                    trk_repeat[i]      = 1'b1;
                    trk_next_repeat[i] = trk_next_repeat[i] + 32'(trk_interval);
                end
            end
        end
        else if (it.event_type == bvr_pkg::KEY_EVENT && it.key_value <= VAL_PRESS)
        begin
            id = button_of(it.key_code);
            if (id >= 0)
            begin
                bit_mask = 18'(1) << id;
                if (it.key_value == VAL_RELEASE)
                begin
                    // duration measured at the latched poll time
                    if (trk_held[id])
                    begin
                        held_for   = trk_poll_time - trk_press_time[id];
                        long_limit = 32'(trk_delay) + 32'(trk_interval);
                        if (held_for > long_limit)
                        begin
                            trk_long = trk_long | bit_mask;
                        end
                        else
                        begin
                            trk_short = trk_short | bit_mask;
                        end
                    end
                    trk_held           = trk_held & ~bit_mask;
                    trk_repeat         = trk_repeat & ~bit_mask;
                    trk_press_time[id] = '0;
                end
                else if (!trk_held[id])
                begin
                    trk_pressed         = trk_pressed | bit_mask;
                    trk_held            = trk_held | bit_mask;
                    trk_press_time[id]  = trk_poll_time;
                    trk_next_repeat[id] = trk_poll_time + 32'(trk_delay);
                end
            end
        end
        res.held_buttons   = trk_held;
        res.newly_pressed  = trk_pressed;
        res.released_long  = trk_long;
        res.released_short = trk_short;
        res.repeated       = trk_repeat;
    endtask

    // send one item and queue the masks it should produce
    task automatic send_item(input key_item_t it);
        mask_set_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.req_type;
        s_tdata  <= {it.key_value, it.key_code, it.event_type, it.now_ms};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_masks(it, res);
        expected_masks.push_back(res);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_masks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write one register, then read it back
    task automatic set_register(input logic idx, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (idx == bvr_pkg::REG_DELAY)
        begin
            trk_delay = value;
        end
        else
        begin
            trk_interval = value;
        end
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata !== {16'h0000, value})
        begin
            $error("prdata mismatch: expected %08h, actual %08h", {16'h0000, value}, prdata);
            failures++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_masks.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                failures++;
            end
            else
            begin
                oldest_mask = expected_masks.pop_front();
                compare_field("held_buttons", oldest_mask.held_buttons, m_tdata[17:0]);
                compare_field("newly_pressed", oldest_mask.newly_pressed, m_tdata[35:18]);
                compare_field("released_long", oldest_mask.released_long, m_tdata[53:36]);
                compare_field("released_short", oldest_mask.released_short, m_tdata[71:54]);
                compare_field("repeated", oldest_mask.repeated, m_tdata[89:72]);
            end
        end
    end

    // ignored items, boundaries and time wrap at reset timing
    task automatic test_special_cases();
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd103, VAL_PRESS));   // press before any poll
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd103, VAL_PRESS));   // press of a held button
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd108, 8'hFF));       // value too large
        send_item(key_item(16'hFFFF, 16'd108, VAL_PRESS));             // other event type
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'hFFFF, VAL_PRESS));  // unmapped code
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd108, VAL_RELEASE)); // release of idle button
        send_item(poll_item(32'd299));
        send_item(poll_item(32'd300));                                 // first repeat is due
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd116, VAL_PRESS));
        send_item(poll_item(32'd700));
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd103, VAL_RELEASE)); // long hold
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd116, VAL_RELEASE)); // delay plus interval
        // repeat time wrapping past zero
        send_item(poll_item(32'hFFFF_FF00));
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'h0001, VAL_PRESS));
        send_item(poll_item(32'hFFFF_FFFF));
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'h0001, VAL_RELEASE));
        drain();
    endtask

    // smallest and largest delay and interval
    task automatic test_timing_extremes();
        set_register(bvr_pkg::REG_DELAY, 16'd0);
        set_register(bvr_pkg::REG_INTERVAL, 16'd0);
        send_item(poll_item(32'd5000));
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd57, VAL_PRESS));
        send_item(poll_item(32'd5000));
        send_item(poll_item(32'd5001));
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd57, VAL_RELEASE));
        drain();
        set_register(bvr_pkg::REG_DELAY, 16'hFFFF);
        set_register(bvr_pkg::REG_INTERVAL, 16'hFFFF);
        send_item(poll_item(32'h0001_0000));
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd29, VAL_PRESS));
        send_item(poll_item(32'h0002_FFFE));
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd29, VAL_RELEASE));
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd29, VAL_PRESS));
        send_item(poll_item(32'h0004_FFFD));
        send_item(key_item(bvr_pkg::KEY_EVENT, 16'd29, VAL_RELEASE));
        drain();
    endtask

    // one random item: mostly polls and clean key events, some noise
    task automatic random_item(output key_item_t it, output bit acted);
        int pick;
        int step_max;
        pick  = $urandom_range(99);
        acted = 1'b1;
        if (pick < 35)
        begin
            step_max = (int'(trk_delay) + int'(trk_interval)) / 2 + 20;
            if ($urandom_range(99) < 3)
            begin
                traffic_ms = $urandom;
            end
            else
            begin
                traffic_ms = traffic_ms + 32'($urandom_range(0, step_max));
            end
            it = poll_item(traffic_ms);
        end
        else if (pick < 88)
        begin
            it = key_item(bvr_pkg::KEY_EVENT, BUTTON_CODES[$urandom_range(17)],
                          ($urandom_range(1) != 0) ? VAL_PRESS : VAL_RELEASE);
        end
        else
        begin
            it = key_item(($urandom_range(1) != 0) ? bvr_pkg::KEY_EVENT : 16'($urandom),
                          ($urandom_range(1) != 0) ? BUTTON_CODES[$urandom_range(17)]
                                                   : 16'($urandom),
                          8'($urandom));
            it.req_type = REQ_KEY;
            acted = 1'b0;
        end
    endtask

    task automatic run_traffic(input int idle_pct, input int hold_pct);
        key_item_t it;
        bit        acted;
        int        sent;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        sent          = 0;
        while (sent < PHASE_ITEMS)
        begin
            random_item(it, acted);
            send_item(it);
            if (acted)
            begin
                sent++;
            end
        end
        drain();
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // random traffic under several timings and idling patterns
    task automatic test_random_traffic();
        set_register(bvr_pkg::REG_DELAY, 16'($urandom_range(0, 400)));
        set_register(bvr_pkg::REG_INTERVAL, 16'($urandom_range(0, 200)));
        run_traffic(0, 0);
        set_register(bvr_pkg::REG_DELAY, 16'd0);
        set_register(bvr_pkg::REG_INTERVAL, 16'($urandom_range(1, 300)));
        run_traffic(52, 0);
        set_register(bvr_pkg::REG_DELAY, bvr_pkg::DELAY_RESET);
        set_register(bvr_pkg::REG_INTERVAL, bvr_pkg::INTERVAL_RESET);
        run_traffic(0, 52);
        set_register(bvr_pkg::REG_DELAY, 16'($urandom));
        set_register(bvr_pkg::REG_INTERVAL, 16'($urandom));
        run_traffic(26, 26);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        failures      = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        traffic_ms    = '0;
        reset_masks();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_special_cases();
        test_timing_extremes();
        test_random_traffic();

        if (failures == 0)
        begin
            $display("button_event_repeat_tracker verification clean");
        end
        else
        begin
            $display("button_event_repeat_tracker verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
